// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SCA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define SCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/sca_pkg.sv =====
// Types and constants of the sound channel allocator.
`default_nettype none

package sca_pkg;

    localparam int CHANNEL_COUNT = 8;
    localparam int CH_W          = $clog2(CHANNEL_COUNT);

    localparam int ID_W     = 8;
    localparam int VOL_W    = 8;
    localparam int SEP_W    = 8;
    localparam int TICK_W   = 31;
    localparam int OUT_CH_W = 3;
    localparam int HANDLE_W = 16;
    localparam int LEVEL_W  = 11;
    localparam int VSAT_W   = 7;

    localparam int EXCL_COUNT = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [VSAT_W-1:0]   VOL_MAX      = 7'd127;
    localparam logic [HANDLE_W-1:0] HANDLE_FIRST = 16'd100;

    localparam logic [ID_W-1:0] EXCL_RESET [EXCL_COUNT] =
        '{8'd10, 8'd11, 8'd12, 8'd13, 8'd22, 8'd1};

    typedef struct packed {
        logic [ID_W-1:0]   effect_id;
        logic [VOL_W-1:0]  volume;
        logic [SEP_W-1:0]  separation;
        logic [TICK_W-1:0] current_tick;
    } sca_in_t;

    typedef struct packed {
        logic [OUT_CH_W-1:0] channel_index;
        logic [HANDLE_W-1:0] handle;
        logic [LEVEL_W-1:0]  play_level;
        logic [LEVEL_W-1:0]  left_level;
        logic [LEVEL_W-1:0]  right_level;
        logic                stop_valid;
        logic [OUT_CH_W-1:0] stop_channel;
    } sca_out_t;

    // One channel table entry as held in the memory.
    typedef struct packed {
        logic [TICK_W-1:0] start_tick;
        logic [ID_W-1:0]   effect;
    } sca_entry_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] left_level;
        logic [LEVEL_W-1:0] right_level;
    } sca_levels_t;

endpackage

`default_nettype wire

// ===== src/sound_channel_allocator.sv =====
// A request is registered on acceptance; the scan state then walks the channel
// memory, one read port entry per cycle, and the write state commits the result.
// A new request is taken only once the last one has been committed.
// A waiting result does not block acceptance of the next request, only its commit.
// Reset clears busy flags, handle counter and control; exclusive ids take
// their defaults. The channel memory is not cleared: busy flags gate it.
`default_nettype none

module sound_channel_allocator
    import sca_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire sca_in_t               in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output sca_out_t                   out_data,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    sca_in_t                in_reg, in_next;
    logic                   excl_hit_reg, excl_hit_next;
    logic [CH_W-1:0]        idx_reg, idx_next;
    logic                   issuing_reg, issuing_next;
    logic                   eval_vld_reg, eval_vld_next;
    logic [CH_W-1:0]        eval_idx_reg, eval_idx_next;
    logic                   stop_vld_reg, stop_vld_next;
    logic [CH_W-1:0]        stop_ch_reg, stop_ch_next;
    logic                   ff_vld_reg, ff_vld_next;
    logic [CH_W-1:0]        ff_reg, ff_next;
    logic [TICK_W-1:0]      oldest_reg, oldest_next;
    logic [CH_W-1:0]        oldest_ch_reg, oldest_ch_next;
    logic [CHANNEL_COUNT-1:0] busy_reg, busy_next;
    logic [HANDLE_W-1:0]    handle_reg, handle_next;
    logic                   out_valid_reg, out_valid_next;
    sca_out_t               out_reg, out_next;
    logic [ID_W-1:0]        excl_reg [EXCL_COUNT];

    logic                   in_accept;
    logic                   excl_match;
    logic                   commit;
    logic [CH_W-1:0]        slot;
    logic [HANDLE_W-1:0]    handle_sel;
    logic [VSAT_W-1:0]      vol_sat;
    logic [$bits(sca_entry_t)-1:0] rd_raw;
    sca_entry_t             rd_entry;
    sca_entry_t             wr_entry;
    sca_levels_t            levels;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign vol_sat = (in_reg.volume > VOL_W'(VOL_MAX)) ? VOL_MAX : in_reg.volume[VSAT_W-1:0];

    always_comb
    begin
        excl_match = 1'b0;
        for (int k = 0; k < EXCL_COUNT; k++)
        begin
            if (excl_reg[k] == in_data.effect_id)
            begin
                excl_match = 1'b1;
            end
        end
    end

    assign rd_entry = sca_entry_t'(rd_raw);
    assign wr_entry = '{start_tick: in_reg.current_tick, effect: in_reg.effect_id};

    sca_ram #(
        .WIDTH ($bits(sca_entry_t)),
        .DEPTH (CHANNEL_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (commit),
        .waddr (slot),
        .wdata (wr_entry),
        .re    (issuing_reg),
        .raddr (idx_reg),
        .rdata (rd_raw)
    );

    sca_pan u_pan (
        .clk    (clk),
        .vol    (vol_sat),
        .sep    (in_reg.separation),
        .levels (levels)
    );

    // Channel choice: a stop frees a channel, so the lower-numbered of it and the first
    // free one wins then; the oldest start counts only when every channel stays busy.
    always_comb
    begin
        priority if (stop_vld_reg)
        begin
            slot = (ff_vld_reg && (ff_reg < stop_ch_reg)) ? ff_reg : stop_ch_reg;
        end
        else if (ff_vld_reg)
        begin
            slot = ff_reg;
        end
        else
        begin
            slot = oldest_ch_reg;
        end
    end

    assign handle_sel = (handle_reg == '0) ? HANDLE_FIRST : handle_reg;
    assign commit     = (state_reg == ST_WRITE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        in_next        = in_reg;
        excl_hit_next  = excl_hit_reg;
        idx_next       = idx_reg;
        issuing_next   = issuing_reg;
        eval_vld_next  = 1'b0;
        eval_idx_next  = eval_idx_reg;
        stop_vld_next  = stop_vld_reg;
        stop_ch_next   = stop_ch_reg;
        ff_vld_next    = ff_vld_reg;
        ff_next        = ff_reg;
        oldest_next    = oldest_reg;
        oldest_ch_next = oldest_ch_reg;
        busy_next      = busy_reg;
        handle_next    = handle_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    in_next        = in_data;
                    excl_hit_next  = excl_match;
                    idx_next       = '0;
                    issuing_next   = 1'b1;
                    stop_vld_next  = 1'b0;
                    ff_vld_next    = 1'b0;
                    oldest_next    = in_data.current_tick;
                    oldest_ch_next = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // read issue runs one entry ahead of evaluation
                if (issuing_reg)
                begin
                    eval_vld_next = 1'b1;
                    eval_idx_next = idx_reg;
                    if (idx_reg == CH_W'(CHANNEL_COUNT - 1))
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + CH_W'(1);
                    end
                end
                if (eval_vld_reg)
                begin
                    if (excl_hit_reg && busy_reg[eval_idx_reg] && !stop_vld_reg &&
                        (rd_entry.effect == in_reg.effect_id))
                    begin
                        stop_vld_next = 1'b1;
                        stop_ch_next  = eval_idx_reg;
                    end
                    if (!busy_reg[eval_idx_reg] && !ff_vld_reg)
                    begin
                        ff_vld_next = 1'b1;
                        ff_next     = eval_idx_reg;
                    end
                    if (rd_entry.start_tick < oldest_reg)
                    begin
                        oldest_next    = rd_entry.start_tick;
                        oldest_ch_next = eval_idx_reg;
                    end
                    if (!issuing_reg)
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                if (commit)
                begin
                    if (stop_vld_reg)
                    begin
                        busy_next[stop_ch_reg] = 1'b0;
                    end
                    busy_next[slot] = 1'b1;
                    handle_next     = handle_sel + HANDLE_W'(1);
                    out_next.channel_index = OUT_CH_W'(slot);
                    out_next.handle        = handle_sel;
                    out_next.play_level    = {vol_sat, 4'b0000};
                    out_next.left_level    = levels.left_level;
                    out_next.right_level   = levels.right_level;
                    out_next.stop_valid    = stop_vld_reg;
                    out_next.stop_channel  = stop_vld_reg ? OUT_CH_W'(stop_ch_reg) : '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            excl_hit_reg  <= 1'b0;
            idx_reg       <= '0;
            issuing_reg   <= 1'b0;
            eval_vld_reg  <= 1'b0;
            stop_vld_reg  <= 1'b0;
            ff_vld_reg    <= 1'b0;
            busy_reg      <= '0;
            handle_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < EXCL_COUNT; k++)
            begin
                excl_reg[k] <= EXCL_RESET[k];
            end
        end
        else
        begin
            state_reg     <= state_next;
            excl_hit_reg  <= excl_hit_next;
            idx_reg       <= idx_next;
            issuing_reg   <= issuing_next;
            eval_vld_reg  <= eval_vld_next;
            stop_vld_reg  <= stop_vld_next;
            ff_vld_reg    <= ff_vld_next;
            busy_reg      <= busy_next;
            handle_reg    <= handle_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (cfg_index < CFG_IDX_W'(EXCL_COUNT)))
            begin
                excl_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg        <= in_next;
        eval_idx_reg  <= eval_idx_next;
        stop_ch_reg   <= stop_ch_next;
        ff_reg        <= ff_next;
        oldest_reg    <= oldest_next;
        oldest_ch_reg <= oldest_ch_next;
        out_reg       <= out_next;
    end

endmodule

`default_nettype wire

// ===== src/sca_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/sca_pan.sv =====
// Quadratic pan pipeline: two multiply stages and one level stage.
`default_nettype none

module sca_pan
    import sca_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [VSAT_W-1:0] vol,
    input  wire logic [SEP_W-1:0]  sep,
    output sca_levels_t            levels
);

    localparam int DIST_W = SEP_W + 1;
    localparam int P1_W   = VSAT_W + DIST_W;
    localparam int P2_W   = P1_W + DIST_W;

    logic [DIST_W-1:0] dist_l;
    logic [DIST_W-1:0] dist_r;
    logic [P1_W-1:0]   l1_reg;
    logic [P1_W-1:0]   r1_reg;
    logic [P2_W-1:0]   l2_reg;
    logic [P2_W-1:0]   r2_reg;
    logic [VSAT_W-1:0] left_diff;
    logic [VSAT_W-1:0] right_diff;

    // s = sep + 1 and 257 - s, both in 1..256
    assign dist_l = {1'b0, sep} + DIST_W'(1);
    assign dist_r = DIST_W'(256) - {1'b0, sep};

    // v*d*d >> 16 never exceeds v, so seven bits of it suffice
    assign left_diff  = vol - l2_reg[16 +: VSAT_W];
    assign right_diff = vol - r2_reg[16 +: VSAT_W];

    always_ff @(posedge clk)
    begin
        l1_reg <= P1_W'(vol) * P1_W'(dist_l);
        r1_reg <= P1_W'(vol) * P1_W'(dist_r);
        l2_reg <= P2_W'(l1_reg) * P2_W'(dist_l);
        r2_reg <= P2_W'(r1_reg) * P2_W'(dist_r);
        levels.left_level  <= {left_diff, 4'b0000};
        levels.right_level <= {right_diff, 4'b0000};
    end

endmodule

`default_nettype wire

// ===== src/sca_checker.sv =====
// Port-level checker for the sound channel allocator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module sca_checker
    import sca_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire sca_out_t              out_data
);

    logic in_accept;

    assign in_accept = in_valid && !in_stall;

    // one request in flight: the input side closes right after a transaction
    `SCA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, in_stall)

    `SCA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                     out_valid && $stable(out_data))

    `SCA_ASSERT_IMPLY(a_handle_floor, clk, rst_n, out_valid,
                      out_data.handle >= HANDLE_FIRST)

    `SCA_ASSERT_IMPLY(a_stop_quiet, clk, rst_n, out_valid && !out_data.stop_valid,
                      out_data.stop_channel == '0)

endmodule

bind sound_channel_allocator sca_checker u_sca_checker (.*);

`default_nettype wire
